/* design/ksfp_pkg.sv */
// ksfp_pkg: shared types, codes and defaults for the k-stack partition block
// used by the modules of k_stacks_fixed_partition apart from ksfp_ram; no dependencies

package ksfp_pkg;

    localparam int DEF_STACK_DEPTH = 256;
    localparam int DEF_NUM_STACKS  = 4;

    localparam int OP_W    = 2;
    localparam int SID_W   = 2;
    localparam int WORD_W  = 32;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 40;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_POP  = 2'd1,
        OP_PEEK = 2'd2
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_OK     = 2'd0,
        STAT_FULL   = 2'd1,
        STAT_EMPTY  = 2'd2,
        STAT_REJECT = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_COUNT,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic ready;
        logic exec;
        logic load_out;
    } ksfp_cmd_t;

    typedef struct packed {
        logic out_free;
    } ksfp_stat_t;

endpackage

/* design/ksfp_ram.sv */
// ksfp_ram: generic single-write, single-read ram with registered read data
// no dependencies

module ksfp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* design/ksfp_ctrl.sv */
// ksfp_ctrl: request sequencer for the k-stack block
// depends on ksfp_pkg; drives the datapath through ksfp_cmd_t

module ksfp_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  ksfp_pkg::ksfp_stat_t stat,
    output ksfp_pkg::ksfp_cmd_t  cmd
);

    import ksfp_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_COUNT;
                end
            end
            S_COUNT:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
            end
            S_COUNT:
            begin
                cmd.exec = 1'b1;
            end
            S_RESULT:
            begin
                cmd.load_out = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* design/ksfp_dp.sv */
// ksfp_dp: request registers, count and storage rams, result register
// depends on ksfp_pkg and ksfp_ram; steered by ksfp_ctrl

module ksfp_dp #(
    parameter int STACK_DEPTH = ksfp_pkg::DEF_STACK_DEPTH,
    parameter int NUM_STACKS  = ksfp_pkg::DEF_NUM_STACKS
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  ksfp_pkg::ksfp_cmd_t         cmd,
    output ksfp_pkg::ksfp_stat_t        stat,
    input  logic                        in_valid,
    input  logic [ksfp_pkg::OP_W-1:0]   in_op,
    input  logic [ksfp_pkg::SID_W-1:0]  in_sid,
    input  logic [ksfp_pkg::WORD_W-1:0] in_word,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [ksfp_pkg::WORD_W-1:0] out_value,
    output logic [ksfp_pkg::STAT_W-1:0] out_status,
    output logic                        out_empty,
    output logic                        out_full
);

    import ksfp_pkg::*;

    localparam int ID_W    = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
    localparam int CNT_W   = $clog2(STACK_DEPTH + 1);
    localparam int STOR_D  = NUM_STACKS * STACK_DEPTH;
    localparam int STOR_AW = $clog2(STOR_D);

    logic              accept;
    logic [OP_W-1:0]   op_reg;
    logic [SID_W-1:0]  sid_reg;
    logic [WORD_W-1:0] word_reg;
    logic [ID_W-1:0]   in_idx;
    logic [ID_W-1:0]   sid_idx;
    logic              in_range;
    logic [NUM_STACKS-1:0] cnt_valid_reg;

    logic [CNT_W-1:0]  cnt_rdata;
    logic [CNT_W-1:0]  cnt_cur;
    logic [CNT_W-1:0]  cnt_new;
    logic              cur_empty;
    logic              cur_full;
    logic [STOR_AW-1:0] base;
    logic [STOR_AW-1:0] addr;
    logic              stor_we;
    logic              stor_re;
    logic [WORD_W-1:0] stor_rdata;

    status_t           stat_next;
    logic              rd_mem_next;
    logic              rd_ones_next;
    status_t           stat_reg;
    logic              rd_mem_reg;
    logic              rd_ones_reg;
    logic              empty_reg;
    logic              full_reg;

    logic              out_valid_reg;
    logic [WORD_W-1:0] out_value_reg;
    logic [STAT_W-1:0] out_status_reg;
    logic              out_empty_reg;
    logic              out_full_reg;
    logic [WORD_W-1:0] value_sel;

    assign accept  = cmd.ready && in_valid;
    assign in_idx  = ID_W'(in_sid);
    assign sid_idx = ID_W'(sid_reg);
    assign in_range = (32'(sid_reg) < 32'(NUM_STACKS));

    // request capture
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= in_op;
            sid_reg  <= in_sid;
            word_reg <= in_word;
        end
    end

    ksfp_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_STACKS),
        .AW    (ID_W)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cmd.exec && in_range),
        .waddr (sid_idx),
        .wdata (cnt_new),
        .re    (accept),
        .raddr (in_idx),
        .rdata (cnt_rdata)
    );

    // a stack whose count was never written holds nothing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_valid_reg <= '0;
        end
        else if (cmd.exec && in_range)
        begin
            cnt_valid_reg[sid_idx] <= 1'b1;
        end
    end

    assign cnt_cur   = (in_range && cnt_valid_reg[sid_idx]) ? cnt_rdata : '0;
    assign cur_empty = (cnt_cur == '0);
    assign cur_full  = (cnt_cur == CNT_W'(STACK_DEPTH));
    assign base      = STOR_AW'(sid_idx) * STOR_AW'(STACK_DEPTH);

    always_comb
    begin
        cnt_new      = cnt_cur;
        stat_next    = STAT_OK;
        rd_mem_next  = 1'b0;
        rd_ones_next = 1'b0;
        stor_we      = 1'b0;
        stor_re      = 1'b0;
        addr         = base + STOR_AW'(cnt_cur);
        if (!in_range)
        begin
            stat_next = STAT_REJECT;
        end
        else
        begin
            unique case (op_reg)
                OP_PUSH:
                begin
                    if (cur_full)
                    begin
                        stat_next = STAT_FULL;
                    end
                    else
                    begin
                        stor_we = cmd.exec;
                        cnt_new = cnt_cur + CNT_W'(1);
                    end
                end
                OP_POP, OP_PEEK:
                begin
                    addr = base + STOR_AW'(cnt_cur - CNT_W'(1));
                    if (cur_empty)
                    begin
                        stat_next    = STAT_EMPTY;
                        rd_ones_next = 1'b1;
                    end
                    else
                    begin
                        stor_re     = cmd.exec;
                        rd_mem_next = 1'b1;
                        if (op_reg == OP_POP)
                        begin
                            cnt_new = cnt_cur - CNT_W'(1);
                        end
                    end
                end
                default:
                begin
                    stat_next = STAT_REJECT;
                end
            endcase
        end
    end

    ksfp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (STOR_D),
        .AW    (STOR_AW)
    ) u_stor_ram (
        .clk   (clk),
        .we    (stor_we),
        .waddr (addr),
        .wdata (word_reg),
        .re    (stor_re),
        .raddr (addr),
        .rdata (stor_rdata)
    );

    // outcome of the access, waits for storage read data
    always_ff @(posedge clk)
    begin
        if (cmd.exec)
        begin
            stat_reg    <= stat_next;
            rd_mem_reg  <= rd_mem_next;
            rd_ones_reg <= rd_ones_next;
            empty_reg   <= in_range && (cnt_new == '0);
            full_reg    <= in_range && (cnt_new == CNT_W'(STACK_DEPTH));
        end
    end

    always_comb
    begin
        priority if (rd_mem_reg)
        begin
            value_sel = stor_rdata;
        end
        else if (rd_ones_reg)
        begin
            value_sel = '1;
        end
        else
        begin
            value_sel = '0;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_value_reg  <= value_sel;
            out_status_reg <= stat_reg;
            out_empty_reg  <= empty_reg;
            out_full_reg   <= full_reg;
        end
    end

    assign stat.out_free = !out_valid_reg || out_ready;
    assign out_valid     = out_valid_reg;
    assign out_value     = out_value_reg;
    assign out_status    = out_status_reg;
    assign out_empty     = out_empty_reg;
    assign out_full      = out_full_reg;

endmodule

/* design/k_stacks_fixed_partition.sv */
// k_stacks_fixed_partition: top level, stream ports around sequencer and datapath
// depends on ksfp_pkg, ksfp_ctrl, ksfp_dp, ksfp_ram

// NUM_STACKS lifo stacks of STACK_DEPTH 32-bit words share one storage ram, stack s
// owning the words from s * STACK_DEPTH. Each request beat pushes, pops or peeks one
// stack and yields exactly one result beat with the word read, a status and the
// stack's empty and full flags afterwards. The count ram is read at the accepting
// edge; the storage access follows in the count state and its read data is loaded
// into the result register in the result state, once the output register is free.
// A request is taken only in idle, so none is accepted while one is in flight.
// The result sits in an output register, and the next request is accepted while it
// waits; a result that cannot be loaded holds the sequencer until the output frees.
// Counts start at zero after reset with no clearing pass.

module k_stacks_fixed_partition #(
    parameter int STACK_DEPTH = ksfp_pkg::DEF_STACK_DEPTH,
    parameter int NUM_STACKS  = ksfp_pkg::DEF_NUM_STACKS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [ksfp_pkg::S_DATA_W-1:0] s_axis_tdata,  // stack_id, push_value, zero pad
    input  logic [ksfp_pkg::OP_W-1:0]     s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [ksfp_pkg::M_DATA_W-1:0] m_axis_tdata,  // read_value, now_empty, now_full, zero pad
    output logic [ksfp_pkg::STAT_W-1:0]   m_axis_tuser   // status
);

    import ksfp_pkg::*;

    localparam int PAD_W = M_DATA_W - WORD_W - 2;

    ksfp_cmd_t         cmd;
    ksfp_stat_t        stat;
    logic [WORD_W-1:0] out_value;
    logic              out_empty;
    logic              out_full;

    ksfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .stat     (stat),
        .cmd      (cmd)
    );

    ksfp_dp #(
        .STACK_DEPTH (STACK_DEPTH),
        .NUM_STACKS  (NUM_STACKS)
    ) u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .stat       (stat),
        .in_valid   (s_axis_tvalid),
        .in_op      (s_axis_tuser),
        .in_sid     (s_axis_tdata[SID_W-1:0]),
        .in_word    (s_axis_tdata[SID_W+WORD_W-1:SID_W]),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_value  (out_value),
        .out_status (m_axis_tuser),
        .out_empty  (out_empty),
        .out_full   (out_full)
    );

    assign s_axis_tready = cmd.ready;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, out_full, out_empty, out_value};

endmodule
